@@ hdl/grid_trimesh_normal_builder_defines.svh @@
`ifndef GRID_TRIMESH_NORMAL_BUILDER_DEFINES_SVH
`define GRID_TRIMESH_NORMAL_BUILDER_DEFINES_SVH

// same-cycle implication
`define GTN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid_trimesh_normal_builder: check failed");

// next-cycle implication
`define GTN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid_trimesh_normal_builder: check failed");

`endif

@@ hdl/gtn_pkg.sv @@
`timescale 1ns / 1ps
package gtn_pkg;

  localparam int GRID_DIM = 16;
  localparam int GRID_W   = $clog2(GRID_DIM);
  localparam int POS_W    = 32;
  localparam int TEMP_W   = 16;
  localparam int NORM_W   = 16;
  localparam int IDX_W    = 32;
  localparam int VEC_W    = 35;
  localparam int MAG_W    = 34;
  localparam int NRM_HI   = 30;
  localparam int PROD_W   = 2 * NRM_HI;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 64;
  localparam int LEN_W    = 31;
  localparam int FRAC_W   = 14;
  localparam int NUM_W    = LEN_W + FRAC_W;
  localparam int QUO_W    = FRAC_W + 1;
  localparam int QCNT_W   = $clog2(QUO_W);
  localparam int EMIT_CNT = 6;
  localparam int EMIT_W   = $clog2(EMIT_CNT);
  localparam int CRS_STEPS = 6;
  localparam int CRS_W    = $clog2(CRS_STEPS);

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic signed [TEMP_W-1:0] t;
  } point_t;

  typedef logic signed [VEC_W-1:0]  vcomp_t;
  typedef logic signed [NORM_W-1:0] ncomp_t;

  typedef enum logic [3:0] {
    UV_IDLE, UV_MAX, UV_NORM, UV_SQ, UV_ACC, UV_SQRT, UV_DSET, UV_DIV, UV_DONE
  } uv_state_e;

  typedef enum logic [3:0] {
    T_IDLE, T_READ, T_E1, T_E1W, T_E2, T_E2W, T_CRM, T_CRA, T_NS, T_NW, T_EMIT, T_UPD
  } top_state_e;

endpackage

@@ hdl/gtn_ram.sv @@
`timescale 1ns / 1ps
module gtn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gtn_unitvec.sv @@
`timescale 1ns / 1ps
module gtn_unitvec (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  gtn_pkg::vcomp_t vec_i [3],
  output logic            done_o,
  output gtn_pkg::ncomp_t unit_o [3]
);
  import gtn_pkg::*;

  uv_state_e state_q, state_d;
  logic [2:0] neg_q, neg_d;
  logic [MAG_W-1:0] m_q [3];
  logic [MAG_W-1:0] m_d [3];
  logic [MAG_W-1:0] mx_q, mx_d, mmax01, mmax;
  logic [1:0] k_q, k_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [ROOT_W-1:0] rn_q, rn_d, res_q, res_d, bit_q, bit_d, trial;
  logic [LEN_W-1:0] len_q, len_d;
  logic [NUM_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [QUO_W-1:0] quo_q, quo_d, quo_n;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  ncomp_t out_q [3];
  ncomp_t out_d [3];
  vcomp_t absv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i] = vec_i[i][VEC_W-1] ? -vec_i[i] : vec_i[i];
    end
    mmax01 = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
    mmax   = (mmax01 > m_q[2]) ? mmax01 : m_q[2];
    trial  = res_q + bit_q;
    quo_n  = {quo_q[QUO_W-2:0], (rem_q >= dvs_q)};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      UV_IDLE: if (start_i) state_d = UV_MAX;
      UV_MAX:  state_d = (mmax == '0) ? UV_DONE : UV_NORM;
      UV_NORM: if (mx_q[MAG_W-1:NRM_HI-1] == 1) state_d = UV_SQ;
      UV_SQ:   state_d = UV_ACC;
      UV_ACC:  state_d = (k_q == 2'd2) ? UV_SQRT : UV_SQ;
      UV_SQRT: if (bit_q[0]) state_d = UV_DSET;
      UV_DSET: state_d = UV_DIV;
      UV_DIV: begin
        if (cnt_q == QCNT_W'(QUO_W - 1)) begin
          state_d = (k_q == 2'd2) ? UV_DONE : UV_DSET;
        end
      end
      UV_DONE: state_d = UV_IDLE;
      default: state_d = UV_IDLE;
    endcase
  end

  always_comb begin
    neg_d = neg_q;
    m_d = m_q;
    mx_d = mx_q;
    k_d = k_q;
    prod_d = prod_q;
    sum_d = sum_q;
    rn_d = rn_q;
    res_d = res_q;
    bit_d = bit_q;
    len_d = len_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    out_d = out_q;
    case (state_q)
      UV_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_d[i] = vec_i[i][VEC_W-1];
          m_d[i] = absv[i][MAG_W-1:0];
        end
      end
      UV_MAX: begin
        mx_d = mmax;
        if (mmax == '0) begin
          for (int i = 0; i < 3; i++) out_d[i] = '0;
        end
      end
      UV_NORM: begin
        if (mx_q[MAG_W-1:NRM_HI] != '0) begin
          mx_d = mx_q >> 1;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (!mx_q[NRM_HI-1]) begin
          mx_d = mx_q << 1;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          k_d = '0;
          sum_d = '0;
        end
      end
      UV_SQ: begin
        prod_d = m_q[k_q][NRM_HI-1:0] * m_q[k_q][NRM_HI-1:0];
      end
      UV_ACC: begin
        sum_d = sum_q + SUM_W'(prod_q);
        if (k_q == 2'd2) begin
          rn_d = ROOT_W'(sum_d);
          res_d = '0;
          bit_d = ROOT_W'(1) << (ROOT_W - 2);
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      UV_SQRT: begin
        if (rn_q >= trial) begin
          rn_d = rn_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          len_d = res_d[LEN_W-1:0];
          k_d = '0;
        end
      end
      UV_DSET: begin
        rem_d = NUM_W'({m_q[k_q][NRM_HI-1:0], FRAC_W'(0)}) + NUM_W'(len_q >> 1);
        dvs_d = {len_q, FRAC_W'(0)};
        quo_d = '0;
        cnt_d = '0;
      end
      UV_DIV: begin
        if (quo_n[0]) rem_d = rem_q - dvs_q;
        quo_d = quo_n;
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q + QCNT_W'(1);
        if (cnt_q == QCNT_W'(QUO_W - 1)) begin
          out_d[k_q] = neg_q[k_q] ? -ncomp_t'({1'b0, quo_n}) : ncomp_t'({1'b0, quo_n});
          k_d = k_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    m_q <= m_d;
    mx_q <= mx_d;
    k_q <= k_d;
    prod_q <= prod_d;
    sum_q <= sum_d;
    rn_q <= rn_d;
    res_q <= res_d;
    bit_q <= bit_d;
    len_q <= len_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign done_o = (state_q == UV_DONE);
  assign unit_o = out_q;

endmodule

@@ hdl/grid_trimesh_normal_builder.sv @@
`timescale 1ns / 1ps
// Grid triangle-mesh builder with face normals.
// Input channel: one grid point per item (pos_x/y/z Q15.16, temperature), row-major,
// GRID_DIM by GRID_DIM per chunk; handshake in_valid_i / in_stall_o.
// Output channel: one vertex per item (position, temperature, Q1.14 face normal,
// vertex index, run_last, chunk_done); handshake out_valid_o / out_stall_i.
// A point in row 0 or column 0 emits nothing and goes from the read to the update.
// Any other point emits six vertices. Six unit-vector passes run on one shared
// iterative unit (normalize shift, squares, 32-step square root, 15-step divide per
// component), plus a cross product per face; the six vertices are emitted once
// both faces are done.
// The block takes one item at a time; in_stall_o is high until the item is done.
// The last vertex sits in an output register, so a new item is accepted while it
// waits. A stalled receiver holds the emit sequence and the output register.
// Reset returns to row 0, column 0, vertex index 0 and first_vertex_index 0; the
// row buffer is not cleared. cfg_we_i writes first_vertex_index, loaded into the
// vertex counter at the first point of every chunk.
`include "grid_trimesh_normal_builder_defines.svh"
module grid_trimesh_normal_builder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gtn_pkg::IDX_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [gtn_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [gtn_pkg::POS_W-1:0]     pos_y_i,
  input  logic signed [gtn_pkg::POS_W-1:0]     pos_z_i,
  input  logic signed [gtn_pkg::TEMP_W-1:0]    temperature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [gtn_pkg::POS_W-1:0]     vert_x_o,
  output logic signed [gtn_pkg::POS_W-1:0]     vert_y_o,
  output logic signed [gtn_pkg::POS_W-1:0]     vert_z_o,
  output logic signed [gtn_pkg::TEMP_W-1:0]    vert_temp_o,
  output logic signed [gtn_pkg::NORM_W-1:0]    norm_x_o,
  output logic signed [gtn_pkg::NORM_W-1:0]    norm_y_o,
  output logic signed [gtn_pkg::NORM_W-1:0]    norm_z_o,
  output logic [gtn_pkg::IDX_W-1:0]            vertex_index_o,
  output logic                                 run_last_o,
  output logic                                 chunk_done_o
);
  import gtn_pkg::*;

  top_state_e state_q, state_d;
  logic [IDX_W-1:0] first_q, nvtx_q, nvtx_d;
  logic [GRID_W-1:0] col_q, col_d, row_q, row_d;
  point_t cur_q, cur_d, p2_q, p2_d, diag_q, diag_d, left_q, left_d;
  point_t ram_rdata, pa, pb, pc, emit_pt;
  logic face_q, face_d;
  ncomp_t u_q [3];
  ncomp_t u_d [3];
  ncomp_t w_q [3];
  ncomp_t w_d [3];
  ncomp_t n1_q [3];
  ncomp_t n1_d [3];
  ncomp_t n2_q [3];
  ncomp_t n2_d [3];
  ncomp_t emit_n [3];
  vcomp_t cr_q [3];
  vcomp_t cr_d [3];
  vcomp_t uv_vec [3];
  ncomp_t uv_unit [3];
  logic uv_start, uv_done;
  logic [CRS_W-1:0] crs_q, crs_d;
  logic [1:0] ia, ib;
  logic signed [2*NORM_W-1:0] prod_q, prod_d;
  logic [EMIT_W-1:0] emit_q, emit_d;
  logic emit_load, edge_pt, last_pt;
  logic in_acc;
  point_t out_pt_q, out_pt_d;
  ncomp_t out_n_q [3];
  ncomp_t out_n_d [3];
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d, out_done_q, out_done_d;

  gtn_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(GRID_DIM)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == T_UPD),
    .waddr_i(col_q),
    .wdata_i(cur_q),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  gtn_unitvec u_unitvec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(uv_start),
    .vec_i  (uv_vec),
    .done_o (uv_done),
    .unit_o (uv_unit)
  );

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign edge_pt = (row_q == '0) || (col_q == '0);
  assign last_pt = (row_q == GRID_W'(GRID_DIM - 1)) && (col_q == GRID_W'(GRID_DIM - 1));
  assign emit_load = !out_valid_q || !out_stall_i;

  always_comb begin
    pa = face_q ? p2_q : diag_q;
    pb = left_q;
    pc = face_q ? cur_q : p2_q;
    uv_start = (state_q == T_E1) || (state_q == T_E2) || (state_q == T_NS);
    if (state_q == T_NS) begin
      uv_vec = cr_q;
    end else if (state_q == T_E2) begin
      uv_vec[0] = vcomp_t'(pc.x) - vcomp_t'(pa.x);
      uv_vec[1] = vcomp_t'(pc.y) - vcomp_t'(pa.y);
      uv_vec[2] = vcomp_t'(pc.z) - vcomp_t'(pa.z);
    end else begin
      uv_vec[0] = vcomp_t'(pb.x) - vcomp_t'(pa.x);
      uv_vec[1] = vcomp_t'(pb.y) - vcomp_t'(pa.y);
      uv_vec[2] = vcomp_t'(pb.z) - vcomp_t'(pa.z);
    end
    case (crs_q)
      3'd0: begin ia = 2'd1; ib = 2'd2; end
      3'd1: begin ia = 2'd2; ib = 2'd1; end
      3'd2: begin ia = 2'd2; ib = 2'd0; end
      3'd3: begin ia = 2'd0; ib = 2'd2; end
      3'd4: begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd0; end
    endcase
    case (emit_q)
      3'd0: begin emit_pt = diag_q; emit_n = n1_q; end
      3'd1: begin emit_pt = p2_q; emit_n = n1_q; end
      3'd2: begin emit_pt = left_q; emit_n = n1_q; end
      3'd3: begin emit_pt = left_q; emit_n = n2_q; end
      3'd4: begin emit_pt = cur_q; emit_n = n2_q; end
      default: begin emit_pt = p2_q; emit_n = n2_q; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: if (in_acc) state_d = T_READ;
      T_READ: state_d = edge_pt ? T_UPD : T_E1;
      T_E1:   state_d = T_E1W;
      T_E1W:  if (uv_done) state_d = T_E2;
      T_E2:   state_d = T_E2W;
      T_E2W:  if (uv_done) state_d = T_CRM;
      T_CRM:  state_d = T_CRA;
      T_CRA:  state_d = (crs_q == CRS_W'(CRS_STEPS - 1)) ? T_NS : T_CRM;
      T_NS:   state_d = T_NW;
      T_NW:   if (uv_done) state_d = face_q ? T_EMIT : T_E1;
      T_EMIT: if (emit_load && emit_q == EMIT_W'(EMIT_CNT - 1)) state_d = T_UPD;
      T_UPD:  state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    nvtx_d = nvtx_q;
    col_d = col_q;
    row_d = row_q;
    cur_d = cur_q;
    p2_d = p2_q;
    diag_d = diag_q;
    left_d = left_q;
    face_d = face_q;
    u_d = u_q;
    w_d = w_q;
    n1_d = n1_q;
    n2_d = n2_q;
    cr_d = cr_q;
    crs_d = crs_q;
    prod_d = prod_q;
    emit_d = emit_q;
    out_pt_d = out_pt_q;
    out_n_d = out_n_q;
    out_idx_d = out_idx_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          cur_d = '{x: pos_x_i, y: pos_y_i, z: pos_z_i, t: temperature_i};
          if (row_q == '0 && col_q == '0) nvtx_d = first_q;
        end
      end
      T_READ: begin
        p2_d = ram_rdata;
        face_d = 1'b0;
      end
      T_E1W: if (uv_done) u_d = uv_unit;
      T_E2W: begin
        if (uv_done) begin
          w_d = uv_unit;
          crs_d = '0;
        end
      end
      T_CRM: prod_d = u_q[ia] * w_q[ib];
      T_CRA: begin
        if (!crs_q[0]) begin
          cr_d[crs_q[2:1]] = vcomp_t'(prod_q);
        end else begin
          cr_d[crs_q[2:1]] = cr_q[crs_q[2:1]] - vcomp_t'(prod_q);
        end
        crs_d = crs_q + CRS_W'(1);
      end
      T_NW: begin
        if (uv_done) begin
          if (face_q) begin
            n2_d = uv_unit;
            emit_d = '0;
          end else begin
            n1_d = uv_unit;
            face_d = 1'b1;
          end
        end
      end
      T_EMIT: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
          out_pt_d = emit_pt;
          out_n_d = emit_n;
          out_idx_d = nvtx_q;
          out_last_d = (emit_q == EMIT_W'(EMIT_CNT - 1));
          out_done_d = (emit_q == EMIT_W'(EMIT_CNT - 1)) && last_pt;
          nvtx_d = nvtx_q + IDX_W'(1);
          emit_d = emit_q + EMIT_W'(1);
        end
      end
      T_UPD: begin
        diag_d = p2_q;
        left_d = cur_q;
        if (col_q == GRID_W'(GRID_DIM - 1)) begin
          col_d = '0;
          row_d = (row_q == GRID_W'(GRID_DIM - 1)) ? '0 : row_q + GRID_W'(1);
        end else begin
          col_d = col_q + GRID_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      first_q <= '0;
      nvtx_q <= '0;
      col_q <= '0;
      row_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) first_q <= cfg_wdata_i;
      nvtx_q <= nvtx_d;
      col_q <= col_d;
      row_q <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    p2_q <= p2_d;
    diag_q <= diag_d;
    left_q <= left_d;
    face_q <= face_d;
    u_q <= u_d;
    w_q <= w_d;
    n1_q <= n1_d;
    n2_q <= n2_d;
    cr_q <= cr_d;
    crs_q <= crs_d;
    prod_q <= prod_d;
    emit_q <= emit_d;
    out_pt_q <= out_pt_d;
    out_n_q <= out_n_d;
    out_idx_q <= out_idx_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign vert_x_o = out_pt_q.x;
  assign vert_y_o = out_pt_q.y;
  assign vert_z_o = out_pt_q.z;
  assign vert_temp_o = out_pt_q.t;
  assign norm_x_o = out_n_q[0];
  assign norm_y_o = out_n_q[1];
  assign norm_z_o = out_n_q[2];
  assign vertex_index_o = out_idx_q;
  assign run_last_o = out_last_q;
  assign chunk_done_o = out_done_q;

  `GTN_ASSERT_IMPL(a_done_on_last, out_valid_o && chunk_done_o, run_last_o)
  `GTN_ASSERT_IMPL(a_uv_wait, uv_done, state_q == T_E1W || state_q == T_E2W || state_q == T_NW)
  `GTN_ASSERT_NEXT(a_accept_read, in_acc, state_q == T_READ)
  `GTN_ASSERT_NEXT(a_emit_end, state_q == T_EMIT && emit_load && out_last_d, state_q == T_UPD)

endmodule

@@ tb/tb_grid_trimesh_normal_builder.sv @@
`timescale 1ns / 1ps
module tb_grid_trimesh_normal_builder;
  import gtn_pkg::*;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [TEMP_W-1:0] t;
  } gpt_t;

  typedef struct {
    gpt_t              p;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nz;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              done;
  } vertex_t;

  class mesh_scoreboard;
    gpt_t             row_buf[GRID_DIM];
    gpt_t             diag_pt;
    gpt_t             left_pt;
    int               col;
    int               row;
    logic [IDX_W-1:0] vtx_ctr;
    logic [IDX_W-1:0] first_idx;
    vertex_t          pending_q[$];
    int               errors;

    function new();
      col = 0;
      row = 0;
      vtx_ctr = '0;
      first_idx = '0;
      errors = 0;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function automatic void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned m[3];
      longint unsigned mx;
      longint unsigned len;
      longint unsigned q;
      bit neg[3];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        neg[k] = v[k] < 0;
        m[k] = neg[k] ? -v[k] : v[k];
        if (m[k] > mx) mx = m[k];
      end
      if (mx == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return;
      end
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 16384 + len / 2) / len;
        o[k] = neg[k] ? -longint'(q) : longint'(q);
      end
    endfunction

    function automatic void face_normal(gpt_t a, gpt_t b, gpt_t c, output longint n[3]);
      longint e1[3];
      longint e2[3];
      longint u[3];
      longint w[3];
      longint cr[3];
      e1[0] = longint'($signed(b.x)) - longint'($signed(a.x));
      e1[1] = longint'($signed(b.y)) - longint'($signed(a.y));
      e1[2] = longint'($signed(b.z)) - longint'($signed(a.z));
      e2[0] = longint'($signed(c.x)) - longint'($signed(a.x));
      e2[1] = longint'($signed(c.y)) - longint'($signed(a.y));
      e2[2] = longint'($signed(c.z)) - longint'($signed(a.z));
      unit_vec(e1, u);
      unit_vec(e2, w);
      cr[0] = u[1] * w[2] - u[2] * w[1];
      cr[1] = u[2] * w[0] - u[0] * w[2];
      cr[2] = u[0] * w[1] - u[1] * w[0];
      unit_vec(cr, n);
    endfunction

    function automatic void push_vertex(gpt_t p, longint n[3], bit last, bit done);
      vertex_t v;
      v.p = p;
      v.nx = n[0][NORM_W-1:0];
      v.ny = n[1][NORM_W-1:0];
      v.nz = n[2][NORM_W-1:0];
      v.idx = vtx_ctr;
      v.last = last;
      v.done = done;
      pending_q = {pending_q, v};
      vtx_ctr = vtx_ctr + 1;
    endfunction

    function automatic void note_point(gpt_t cur);
      gpt_t   up;
      longint na[3];
      longint nb[3];
      bit     done;
      if (row == 0 && col == 0) vtx_ctr = first_idx;
      up = row_buf[col];
      if (row > 0 && col > 0) begin
        done = (row == GRID_DIM - 1) && (col == GRID_DIM - 1);
        face_normal(diag_pt, left_pt, up, na);
        face_normal(up, left_pt, cur, nb);
        push_vertex(diag_pt, na, 0, 0);
        push_vertex(up, na, 0, 0);
        push_vertex(left_pt, na, 0, 0);
        push_vertex(left_pt, nb, 0, 0);
        push_vertex(cur, nb, 0, 0);
        push_vertex(up, nb, 1, done);
      end
      diag_pt = up;
      row_buf[col] = cur;
      left_pt = cur;
      col++;
      if (col >= GRID_DIM) begin
        col = 0;
        row++;
        if (row >= GRID_DIM) row = 0;
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_vertex(vertex_t got);
      vertex_t w;
      if (pending_q.size() == 0) begin
        report("unexpected vertex index", got.idx, 0);
        return;
      end
      w = pending_q.pop_front();
      if (got.p.x !== w.p.x) report("vert_x", got.p.x, w.p.x);
      if (got.p.y !== w.p.y) report("vert_y", got.p.y, w.p.y);
      if (got.p.z !== w.p.z) report("vert_z", got.p.z, w.p.z);
      if (got.p.t !== w.p.t) report("vert_temp", got.p.t, w.p.t);
      if (got.nx !== w.nx) report("norm_x", got.nx, w.nx);
      if (got.ny !== w.ny) report("norm_y", got.ny, w.ny);
      if (got.nz !== w.nz) report("norm_z", got.nz, w.nz);
      if (got.idx !== w.idx) report("vertex_index", got.idx, w.idx);
      if (got.last !== w.last) report("run_last", got.last, w.last);
      if (got.done !== w.done) report("chunk_done", got.done, w.done);
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [IDX_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [POS_W-1:0]  pos_x_i;
  logic signed [POS_W-1:0]  pos_y_i;
  logic signed [POS_W-1:0]  pos_z_i;
  logic signed [TEMP_W-1:0] temperature_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [POS_W-1:0]  vert_x_o;
  logic signed [POS_W-1:0]  vert_y_o;
  logic signed [POS_W-1:0]  vert_z_o;
  logic signed [TEMP_W-1:0] vert_temp_o;
  logic signed [NORM_W-1:0] norm_x_o;
  logic signed [NORM_W-1:0] norm_y_o;
  logic signed [NORM_W-1:0] norm_z_o;
  logic [IDX_W-1:0]         vertex_index_o;
  logic                     run_last_o;
  logic                     chunk_done_o;

  mesh_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_left;

  grid_trimesh_normal_builder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .temperature_i (temperature_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vert_x_o      (vert_x_o),
    .vert_y_o      (vert_y_o),
    .vert_z_o      (vert_z_o),
    .vert_temp_o   (vert_temp_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .vertex_index_o(vertex_index_o),
    .run_last_o    (run_last_o),
    .chunk_done_o  (chunk_done_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // hold off the output for a counted stretch, else stall at random
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.p.x = vert_x_o;
      got.p.y = vert_y_o;
      got.p.z = vert_z_o;
      got.p.t = vert_temp_o;
      got.nx = norm_x_o;
      got.ny = norm_y_o;
      got.nz = norm_z_o;
      got.idx = vertex_index_o;
      got.last = run_last_o;
      got.done = chunk_done_o;
      sb.check_vertex(got);
    end
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task send_point(gpt_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pos_x_i       <= p.x;
    pos_y_i       <= p.y;
    pos_z_i       <= p.z;
    temperature_i <= p.t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_point(p);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task cfg_write(logic [IDX_W-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.first_idx = val;
  endtask

  function automatic logic [31:0] pick_coord(int kind);
    case (kind)
      0: return $urandom & 32'h001F_FFFF;
      1: return $urandom;
      2: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic gpt_t rand_point();
    gpt_t p;
    int   kind;
    kind = $urandom_range(99);
    kind = (kind < 55) ? 0 : (kind < 80) ? 1 : (kind < 92) ? 2 : 3;
    p.x = pick_coord(kind);
    p.y = pick_coord(kind);
    p.z = pick_coord(kind);
    p.t = TEMP_W'($urandom);
    return p;
  endfunction

  task run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_point(rand_point());
  endtask

  initial begin
    gpt_t p;
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    temperature_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // vertex counter near the top so it wraps
    cfg_write(32'hFFFF_FFFD);

    // directed: extremes, coincident points and plain slopes
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: begin p.x = 32'h7FFF_FFFF; p.y = 32'h8000_0000; p.z = 32'h7FFF_FFFF; p.t = 16'h7FFF; end
        1: begin p.x = 32'h8000_0000; p.y = 32'h7FFF_FFFF; p.z = 32'h8000_0000; p.t = 16'h8000; end
        2: begin p.x = 32'h0001_0000; p.y = 32'h0001_0000; p.z = 32'h0001_0000; p.t = 16'h0000; end
        3: begin p.x = 32'h0001_0000; p.y = 32'h0001_0000; p.z = 32'h0001_0000; p.t = 16'hFFFF; end
        4: begin p.x = i << 16; p.y = 32'h0; p.z = 32'hFFFF_0000; p.t = TEMP_W'(i); end
        default: begin p.x = '0; p.y = 32'hFFFF_FFFF; p.z = i << 16; p.t = 16'h5A5A; end
      endcase
      send_point(p);
    end

    run_random(60, 0, 0);
    cfg_write(32'h0000_0000);
    run_random(60, 86, 0);
    run_random(60, 0, 86);
    cfg_write($urandom);
    run_random(60, 27, 27);

    // hold the output long enough to back up the input
    stall_pct = 0;
    send_idle_pct = 0;
    hold_left = 3000;
    run_random(10, 0, 0);
    drain();
    run_random(10, 0, 0);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/gtn_pkg.sv
hdl/gtn_ram.sv
hdl/gtn_unitvec.sv
hdl/grid_trimesh_normal_builder.sv
tb/tb_grid_trimesh_normal_builder.sv
